>>> design/kegf_pkg.sv
package kegf_pkg;

  // Width of the hold register and its value after reset.
  localparam int unsigned HOLD_W     = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

  // Default width of the age counters.
  localparam int unsigned AGE_BITS_DEF = 16;

  // Configuration port layout: one 32-bit register at byte address 0.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_HOLD_TICKS = 1'b0;

  // Item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Received key codes.
  localparam logic [7:0] CODE_DIT_DOWN = 8'd1;
  localparam logic [7:0] CODE_DIT_UP   = 8'd2;
  localparam logic [7:0] CODE_DAH_DOWN = 8'd3;
  localparam logic [7:0] CODE_DAH_UP   = 8'd4;

  // Channel numbers, also the high bit of a released edge code.
  localparam logic CH_DIT = 1'b0;
  localparam logic CH_DAH = 1'b1;

  // Released edge codes are {channel, is_up}.
  localparam int unsigned EV_W = 2;

  // Results of one item: one or two released events, ev0 released first.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [EV_W-1:0] ev0;
    logic [EV_W-1:0] ev1;
  } grp_t;

  // Queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

endpackage

>>> design/kegf_in_if.sv
interface kegf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] code;

  modport source (output valid, output kind, output code, input ready);
  modport sink (input valid, input kind, input code, output ready);
endinterface

>>> design/kegf_out_if.sv
interface kegf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       last;

  modport source (output valid, output event_res, output last, input ready);
  modport sink (input valid, input event_res, input last, output ready);
endinterface

>>> design/kegf_queue.sv
module kegf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kegf_pkg::grp_t   push_data,
  input  logic             pop,
  output kegf_pkg::grp_t   head,
  output kegf_pkg::q_stat_t stat
);
  import kegf_pkg::*;

  grp_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign do_push = push && (count_r != Q_CNT_W'(Q_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

>>> design/kegf_front.sv
module kegf_front #(
  parameter int unsigned AGE_BITS = kegf_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [kegf_pkg::HOLD_W-1:0] hold_ticks,
  kegf_in_if.sink                     in_if,
  input  kegf_pkg::q_stat_t           q_stat,
  output logic                        push,
  output kegf_pkg::grp_t              push_data
);
  import kegf_pkg::*;

  // Compare width wide enough for both the hold value and the age.
  localparam int unsigned CW = (AGE_BITS > HOLD_W) ? AGE_BITS : HOLD_W;

  logic                act_r [2], act_nxt [2];
  logic                up_r  [2], up_nxt  [2];
  logic [AGE_BITS-1:0] age_r [2], age_nxt [2];

  logic                accept, is_tick, code_ok, sel, code_up;
  logic [CW-1:0]       hold_ext, agemax_ext, lim;
  logic [AGE_BITS-1:0] aged [2];
  logic                fl [2];
  logic                act_f [2];
  logic                rep;
  logic [EV_W-1:0]     ev_fl [2];
  logic [EV_W-1:0]     ev_rep;

  // Every item is taken while the queue has room for its results.
  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;
  assign is_tick     = (in_if.kind == KIND_TICK);

  // Decode of the received byte.
  assign code_ok = (in_if.code >= CODE_DIT_DOWN) && (in_if.code <= CODE_DAH_UP);
  assign sel     = (in_if.code >= CODE_DAH_DOWN) ? CH_DAH : CH_DIT;
  assign code_up = (in_if.code == CODE_DIT_UP) || (in_if.code == CODE_DAH_UP);

  // Ages saturate at the smaller of hold_ticks and the counter maximum.
  assign hold_ext   = CW'(hold_ticks);
  assign agemax_ext = CW'({AGE_BITS{1'b1}});
  assign lim        = (hold_ext < agemax_ext) ? hold_ext : agemax_ext;

  // Ageing on a tick, then the expiry check for each channel.
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      aged[ch] = age_r[ch];
      if (is_tick && act_r[ch] && (CW'(age_r[ch]) < lim)) begin
        aged[ch] = age_r[ch] + 1'b1;
      end
      fl[ch]    = act_r[ch] && (CW'(aged[ch]) >= hold_ext);
      act_f[ch] = act_r[ch] && !fl[ch];
      ev_fl[ch] = {1'(ch), up_r[ch]};
    end
  end

  // Byte handling after the flush: store, cancel or repeat.
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      act_nxt[ch] = act_f[ch];
      up_nxt[ch]  = up_r[ch];
      age_nxt[ch] = aged[ch];
    end
    rep = 1'b0;
    if (!is_tick && code_ok) begin
      if (!act_f[sel]) begin
        act_nxt[sel] = 1'b1;
        up_nxt[sel]  = code_up;
        age_nxt[sel] = '0;
      end else if (code_up != up_r[sel]) begin
        act_nxt[sel] = 1'b0;
      end else begin
        rep          = 1'b1;
        age_nxt[sel] = '0;
      end
    end
  end

  assign ev_rep = {sel, up_r[sel]};

  // Pack the released edges in order: dit flush, dah flush, repeat.
  always_comb begin
    push_data.cnt = 2'({1'b0, fl[0]} + {1'b0, fl[1]} + {1'b0, rep});
    if (fl[0]) begin
      push_data.ev0 = ev_fl[0];
    end else if (fl[1]) begin
      push_data.ev0 = ev_fl[1];
    end else begin
      push_data.ev0 = ev_rep;
    end
    push_data.ev1 = (fl[0] && fl[1]) ? ev_fl[1] : ev_rep;
  end

  assign push = accept && (fl[0] || fl[1] || rep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < 2; ch++) begin
        act_r[ch] <= 1'b0;
        up_r[ch]  <= 1'b0;
        age_r[ch] <= '0;
      end
    end else if (accept) begin
      for (int ch = 0; ch < 2; ch++) begin
        act_r[ch] <= act_nxt[ch];
        up_r[ch]  <= up_nxt[ch];
        age_r[ch] <= age_nxt[ch];
      end
    end
  end

endmodule

>>> design/kegf_back.sv
module kegf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  kegf_pkg::grp_t    head,
  input  kegf_pkg::q_stat_t q_stat,
  output logic              pop,
  kegf_out_if.source        out_if
);
  import kegf_pkg::*;

  logic            out_valid_r, out_valid_nxt;
  logic [EV_W-1:0] out_ev_r, out_ev_nxt;
  logic            out_last_r, out_last_nxt;
  logic            spare_valid_r, spare_valid_nxt;
  logic [EV_W-1:0] spare_ev_r, spare_ev_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_if.ready;

  // Load the output register from the held spare event or the queue head.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_ev_nxt      = out_ev_r;
    out_last_nxt    = out_last_r;
    spare_valid_nxt = spare_valid_r;
    spare_ev_nxt    = spare_ev_r;
    pop             = 1'b0;
    if (out_free) begin
      if (spare_valid_r) begin
        out_valid_nxt   = 1'b1;
        out_ev_nxt      = spare_ev_r;
        out_last_nxt    = 1'b1;
        spare_valid_nxt = 1'b0;
      end else if (!q_stat.empty) begin
        pop             = 1'b1;
        out_valid_nxt   = 1'b1;
        out_ev_nxt      = head.ev0;
        out_last_nxt    = (head.cnt == 2'd1);
        spare_valid_nxt = (head.cnt == 2'd2);
        spare_ev_nxt    = head.ev1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
    end else begin
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
    end
  end

  // Beat payload needs no reset.
  always_ff @(posedge clk) begin
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
    spare_ev_r <= spare_ev_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.event_res = out_ev_r;
  assign out_if.last      = out_last_r;

endmodule

>>> design/key_edge_glitch_filter.sv
// Two-channel glitch filter for paddle key edge codes.
// in_if carries one beat per item: kind 0 delivers a received code byte
// (1 dit down, 2 dit up, 3 dah down, 4 dah up), kind 1 marks one time tick.
// out_if carries released edges (0 dit down, 1 dit up, 2 dah down, 3 dah up);
// last is high on the final edge caused by an item. Items that release
// nothing produce no beat.
// The front part takes one item per cycle while the queue has room, updates
// both channels and queues the item's edges; the back part sends one edge per
// cycle from its output register while the receiver is ready. An item's first
// edge passes through the queue, then the output register. With the receiver
// ready, items releasing at most one edge keep a rate of one item per cycle;
// items that each release two are held back by the single output register.
// hold_ticks sits at byte address 0 of the APB port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Synchronous active-low reset clears both channels, the two-entry queue
// and the output register, and sets hold_ticks to 1000.
// When the receiver stalls, the queue fills and in_if.ready drops once it
// holds two items.
module key_edge_glitch_filter #(
  parameter int unsigned AGE_BITS = kegf_pkg::AGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  kegf_in_if.sink                         in_if,
  kegf_out_if.source                      out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kegf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [kegf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [kegf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import kegf_pkg::*;

  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              cfg_wr;
  logic              push, pop;
  grp_t              push_data, head;
  q_stat_t           q_stat;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HOLD_TICKS);
  assign hold_nxt = cfg_wr ? pwdata[HOLD_W-1:0] : hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_HOLD_TICKS) ? APB_DATA_W'(hold_r) : '0;

  kegf_front #(
    .AGE_BITS (AGE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_ticks (hold_r),
    .in_if      (in_if),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  kegf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  kegf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

`ifndef NO_ASSERTIONS
  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue push while full");

  // A queued group always carries one or two events.
  a_grp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_data.cnt == 2'd1 || push_data.cnt == 2'd2))
    else $error("queued group with bad edge count");

  // A beat that is not the last of its item is followed by another beat.
  a_group_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && !out_if.last) |=> out_if.valid)
    else $error("second edge of an item missing");

  // A register write lands in hold_ticks.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (hold_r == $past(pwdata[HOLD_W-1:0])))
    else $error("hold_ticks write lost");
`endif

endmodule

>>> dv/kegf_release_chk.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts the released edges of
// every accepted item and compares them with the beats that leave the block.
module kegf_release_chk
  import kegf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  kegf_in_if                    in_mon,
  kegf_out_if                   out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  output int unsigned           fail_cnt,
  output int unsigned           edges_owed
);

  localparam int unsigned AGE_W = AGE_BITS_DEF;
  localparam logic [APB_ADDR_W-1:0] HOLD_ADDR = APB_ADDR_W'(4 * REG_HOLD_TICKS);

  typedef struct packed {
    logic [EV_W-1:0] ev;
    logic            last;
  } edge_beat_t;

  // Released edges still owed by the block, oldest first.
  edge_beat_t released_q[$];
  edge_beat_t want;

  // Shadow of both key channels and of the hold register.
  logic              ch_on[2];
  logic              ch_up[2];
  int unsigned       ch_age[2];
  logic [HOLD_W-1:0] hold;
  int unsigned       errs;

  // Applies one input item to the shadow channels and queues its edges.
  task automatic filter_item(input logic k, input logic [7:0] c);
    logic [EV_W-1:0] evs[2];
    int unsigned     n;
    int unsigned     cap;
    int unsigned     ch;
    logic            up;
    n = 0;
    cap = (AGE_W >= 32) ? 32'hFFFF_FFFF : (32'd1 << AGE_W) - 32'd1;
    if (hold < cap) cap = hold;

    // A tick ages each pending edge, saturating at the smaller of the hold time and the age maximum.
    if (k == KIND_TICK) begin
      for (int i = 0; i < 2; i++) begin
        if (ch_on[i] && ch_age[i] < cap) ch_age[i]++;
      end
    end

    // Expired edges go out first, dit before dah.
    for (int i = 0; i < 2; i++) begin
      if (ch_on[i] && ch_age[i] >= hold) begin
        evs[n] = {i[0], ch_up[i]};
        n++;
        ch_on[i] = 1'b0;
      end
    end

    // A known code is stored, cancels the pending edge, or replaces it.
    if (k == KIND_BYTE && c >= CODE_DIT_DOWN && c <= CODE_DAH_UP) begin
      ch = (c >= CODE_DAH_DOWN) ? 1 : 0;
      up = (c == CODE_DIT_UP) || (c == CODE_DAH_UP);
      if (!ch_on[ch]) begin
        ch_on[ch] = 1'b1;
        ch_up[ch] = up;
        ch_age[ch] = 0;
      end else if (up != ch_up[ch]) begin
        ch_on[ch] = 1'b0;
      end else begin
        evs[n] = {ch[0], ch_up[ch]};
        n++;
        ch_age[ch] = 0;
      end
    end

    for (int unsigned i = 0; i < n; i++) begin
      released_q.push_back('{ev: evs[i], last: (i == n - 1)});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      released_q.delete();
      for (int i = 0; i < 2; i++) begin
        ch_on[i] = 1'b0;
        ch_up[i] = 1'b0;
        ch_age[i] = 0;
      end
      hold = HOLD_RESET;
      errs = 0;
    end else begin
      // Compare each output beat with the oldest predicted edge.
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (released_q.size() == 0) begin
          errs++;
          $display("%0t: edge beat with none expected: actual event %0d last %b",
                   $time, out_mon.event_res, out_mon.last);
        end else begin
          want = released_q.pop_front();
          if (out_mon.event_res !== want.ev) begin
            errs++;
            $display("%0t: event mismatch: expected %0d actual %0d",
                     $time, want.ev, out_mon.event_res);
          end
          if (out_mon.last !== want.last) begin
            errs++;
            $display("%0t: last mismatch: expected %b actual %b",
                     $time, want.last, out_mon.last);
          end
        end
      end

      // Output beats of this edge cannot stem from an item accepted now.
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        filter_item(in_mon.kind, in_mon.code);
      end

      // Track writes to the hold register and check reads of it.
      if (psel && penable && pready && paddr == HOLD_ADDR) begin
        if (pwrite) begin
          hold = pwdata[HOLD_W-1:0];
        end else if (prdata[HOLD_W-1:0] !== hold) begin
          errs++;
          $display("%0t: hold_ticks readback mismatch: expected %0d actual %0d",
                   $time, hold, prdata[HOLD_W-1:0]);
        end
      end
    end
    fail_cnt <= errs;
    edges_owed <= released_q.size();
  end

endmodule

>>> dv/key_edge_glitch_filter_tb.sv
`timescale 1ns / 100ps

module key_edge_glitch_filter_tb;
  import kegf_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam logic [APB_ADDR_W-1:0] HOLD_ADDR = APB_ADDR_W'(4 * REG_HOLD_TICKS);

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           fail_cnt;
  int unsigned           edges_owed;
  int unsigned           burst_left;
  bit                    stall_req;
  bit                    stall_done;

  kegf_in_if  key_in();
  kegf_out_if edge_out();

  key_edge_glitch_filter DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (key_in),
    .out_if  (edge_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kegf_release_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (key_in),
    .out_mon    (edge_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .fail_cnt   (fail_cnt),
    .edges_owed (edges_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one item, opening a new burst after a random gap when one ends.
  task automatic send_item(input logic k, input logic [7:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        key_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    key_in.valid <= 1'b1;
    key_in.kind <= k;
    key_in.code <= c;
    do @(posedge clk); while (key_in.ready !== 1'b1);
    burst_left--;
  endtask

  // Mostly ticks and key codes, with some unknown bytes mixed in.
  task automatic send_random(input int unsigned count);
    logic        k;
    logic [7:0]  c;
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      c = 8'($urandom_range(0, 255));
      if (roll < 45) begin
        k = KIND_TICK;
      end else begin
        k = KIND_BYTE;
        if (roll < 94) c = CODE_DIT_DOWN + 8'($urandom_range(0, 3));
      end
      send_item(k, c);
    end
  endtask

  // One register access: setup cycle, access cycle until pready, then idle with
  // psel low so that accesses never overlap.
  task automatic reg_access(input logic wr, input logic [HOLD_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= HOLD_ADDR;
    pwdata <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Lets the block drain, then writes hold_ticks and reads it back.
  task automatic set_hold(input logic [HOLD_W-1:0] v);
    key_in.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (edges_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_access(1'b1, v);
    reg_access(1'b0, v);
  endtask

  // Receiver: ready follows one of four random patterns, chosen anew after each
  // span of random length, with one long hold-off on request.
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    stall_done = 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      repeat (span) begin
        if (stall_req && !stall_done) begin
          edge_out.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          stall_done = 1'b1;
        end
        case (mode)
          RX_OPEN:   edge_out.ready <= 1'b1;
          RX_COIN:   edge_out.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: edge_out.ready <= ($urandom_range(0, 4) != 0);
          default:   edge_out.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((key_in.valid === 1'b1 && key_in.ready === 1'b1) ||
          (edge_out.valid === 1'b1 && edge_out.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus: directed items under several hold times, then random phases.
  initial begin
    rst_n <= 1'b0;
    key_in.valid <= 1'b0;
    key_in.kind <= KIND_BYTE;
    key_in.code <= 8'd0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    burst_left = 0;
    stall_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset hold time: store, repeat, cancel, unknown bytes.
    send_item(KIND_BYTE, CODE_DIT_DOWN);
    send_item(KIND_BYTE, CODE_DIT_DOWN);
    send_item(KIND_BYTE, CODE_DAH_DOWN);
    send_item(KIND_BYTE, CODE_DAH_UP);
    send_item(KIND_BYTE, 8'd0);
    send_item(KIND_BYTE, 8'd255);
    send_item(KIND_TICK, 8'd255);

    // Hold of 1: release on tick, two released events from one tick.
    set_hold(16'd1);
    send_item(KIND_TICK, 8'd0);
    send_item(KIND_BYTE, CODE_DIT_UP);
    send_item(KIND_BYTE, CODE_DAH_UP);
    send_item(KIND_TICK, 8'd0);
    send_item(KIND_BYTE, CODE_DAH_DOWN);
    send_item(KIND_BYTE, 8'd5);
    send_item(KIND_TICK, 8'd170);

    // Zero hold: every pending edge goes out on the next item's flush.
    set_hold(16'd0);
    send_item(KIND_BYTE, CODE_DIT_DOWN);
    send_item(KIND_BYTE, CODE_DIT_UP);
    send_item(KIND_BYTE, CODE_DAH_UP);
    send_item(KIND_BYTE, CODE_DIT_DOWN);

    // Longest hold: edges stay pending across the next register write.
    set_hold(16'hFFFF);
    send_item(KIND_BYTE, CODE_DAH_DOWN);
    send_item(KIND_TICK, 8'd85);
    send_item(KIND_TICK, 8'd0);
    send_item(KIND_BYTE, CODE_DAH_DOWN);

    set_hold(16'd2);
    send_random(250);

    // The receiver holds off while items keep coming.
    set_hold(16'd1);
    stall_req = 1'b1;
    send_random(300);

    set_hold(16'($urandom_range(3, 16)));
    send_random(250);

    set_hold(16'hFFFF);
    send_random(60);

    set_hold(16'd0);
    send_random(40);

    set_hold(16'($urandom_range(1, 8)));
    send_random(300);

    key_in.valid <= 1'b0;
    @(posedge clk);
    while (edges_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/kegf_pkg.sv
design/kegf_in_if.sv
design/kegf_out_if.sv
design/kegf_queue.sv
design/kegf_front.sv
design/kegf_back.sv
design/key_edge_glitch_filter.sv
dv/kegf_release_chk.sv
dv/key_edge_glitch_filter_tb.sv
